// File: rtl/mexp_pkg.sv
// Package for the modular exponentiation core: operand widths, the
// controller/datapath command and status structs, and the modular fold.
// No dependencies; every other file imports it.
package mexp_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int FIELD_W = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [OPERAND_WIDTH:0] wide_t;
	typedef logic [CNT_W-1:0] bit_cnt_t;

	localparam operand_t MODULUS_RESET = operand_t'(2);
	localparam bit_cnt_t BIT_CNT_MAX = bit_cnt_t'(OPERAND_WIDTH - 1);

	typedef struct packed {
		logic load;
		logic reduce;
		logic lane_clr;
		logic dbl;
		logic add;
		logic red_done;
		logic step_done;
		logic result_load;
	} mexp_cmd_t;

	typedef struct packed {
		logic m_small;
		logic exp_zero;
		logic exp_last;
	} mexp_sts_t;

	// The sum is always below twice the modulus, so one subtraction suffices.
	function automatic operand_t mod_fold(wide_t s, operand_t m);
		wide_t mw;
		mw = {1'b0, m};
		if (s >= mw) begin
			return operand_t'(s - mw);
		end
		return operand_t'(s);
	endfunction

endpackage

// File: rtl/mexp_if.sv
// Request, response and configuration channel interfaces of the
// modular exponentiation core, each with valid/ready handshake.
// Depends on mexp_pkg.
interface mexp_req_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] message;
	logic [FIELD_W-1:0] exponent;

	modport source (output valid, output message, output exponent, input ready);
	modport sink (input valid, input message, input exponent, output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] power_mod;

	modport source (output valid, output power_mod, input ready);
	modport sink (input valid, input power_mod, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
	logic valid;
	logic ready;
	logic [FIELD_W-1:0] modulus;

	modport source (output valid, output modulus, input ready);
	modport sink (input valid, input modulus, output ready);
endinterface

// File: rtl/mexp_lane.sv
// One shift-and-add modular multiplier lane: a doubling step and a
// conditional add step per multiplier bit, each folded below the modulus.
// Depends on mexp_pkg.
module mexp_lane import mexp_pkg::*; (
	input logic clk,
	input mexp_cmd_t cmd,
	input operand_t a,
	input operand_t m,
	input logic bbit,
	output operand_t sum
);

	operand_t r_q;
	operand_t dbl_val;
	operand_t add_val;

	always_comb begin
		dbl_val = mod_fold({r_q, 1'b0}, m);
		add_val = bbit ? mod_fold({1'b0, r_q} + {1'b0, a}, m) : r_q;
	end

	assign sum = add_val;

	always_ff @(posedge clk) begin
		if (cmd.lane_clr) begin
			r_q <= '0;
		end else if (cmd.dbl) begin
			r_q <= dbl_val;
		end else if (cmd.add) begin
			r_q <= add_val;
		end
	end

endmodule

// File: rtl/mexp_datapath.sv
// Datapath: modulus register, accumulator, base, exponent and multiplier
// shift registers, two multiplier lanes and the result register.
// Depends on mexp_pkg and mexp_lane.
module mexp_datapath import mexp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mexp_cmd_t cmd,
	output mexp_sts_t sts,
	input logic cfg_we,
	input logic [FIELD_W-1:0] cfg_data,
	input logic [FIELD_W-1:0] message,
	input logic [FIELD_W-1:0] exponent,
	output logic [FIELD_W-1:0] power_mod
);

	operand_t m_q;
	operand_t acc_q;
	operand_t base_q;
	operand_t b_q;
	operand_t exp_q;
	operand_t res_q;
	operand_t acc_sum;
	operand_t base_sum;
	operand_t base_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			m_q <= cfg_data[OPERAND_WIDTH-1:0];
		end
	end

	// During the reduction pass the base lane multiplies the message by one.
	assign base_a = cmd.reduce ? operand_t'(1) : base_q;

	mexp_lane u_acc_lane (
		.clk (clk),
		.cmd (cmd),
		.a (acc_q),
		.m (m_q),
		.bbit (b_q[OPERAND_WIDTH-1]),
		.sum (acc_sum)
	);

	mexp_lane u_base_lane (
		.clk (clk),
		.cmd (cmd),
		.a (base_a),
		.m (m_q),
		.bbit (b_q[OPERAND_WIDTH-1]),
		.sum (base_sum)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q <= message[OPERAND_WIDTH-1:0];
			exp_q <= exponent[OPERAND_WIDTH-1:0];
			acc_q <= operand_t'(1);
		end else begin
			if (cmd.add) begin
				b_q <= b_q << 1;
			end
			if (cmd.red_done) begin
				base_q <= base_sum;
				b_q <= base_sum;
			end
			if (cmd.step_done) begin
				if (exp_q[0]) begin
					acc_q <= acc_sum;
				end
				base_q <= base_sum;
				b_q <= base_sum;
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.result_load) begin
			res_q <= sts.m_small ? '0 : acc_q;
		end
	end

	always_comb begin
		sts.m_small = (m_q >> 1) == '0;
		sts.exp_zero = exp_q == '0;
		sts.exp_last = (exp_q >> 1) == '0;
	end

	assign power_mod = FIELD_W'(res_q);

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences the reduction pass and one square-and-multiply
// step per exponent bit, and owns the request and response handshakes.
// Depends on mexp_pkg.
module mexp_ctrl import mexp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input mexp_sts_t sts,
	output mexp_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_DBL, S_ADD, S_FINISH} state_t;

	state_t state_q;
	logic reduce_q;
	bit_cnt_t cnt_q;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.reduce = reduce_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.lane_clr = 1'b1;
				end
			end
			S_DBL: begin
				cmd.dbl = 1'b1;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (cnt_q == '0) begin
					cmd.lane_clr = 1'b1;
					cmd.red_done = reduce_q;
					cmd.step_done = !reduce_q;
				end
			end
			S_FINISH: begin
				cmd.result_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			reduce_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= BIT_CNT_MAX;
						reduce_q <= 1'b1;
						state_q <= sts.m_small ? S_FINISH : S_DBL;
					end
				end
				S_DBL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - bit_cnt_t'(1);
						state_q <= S_DBL;
					end else begin
						cnt_q <= BIT_CNT_MAX;
						reduce_q <= 1'b0;
						// Stop once no set exponent bit remains.
						if (reduce_q ? sts.exp_zero : sts.exp_last) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_DBL;
						end
					end
				end
				S_FINISH: begin
					if (cmd.result_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_step_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_done |-> !reduce_q && cnt_q == '0)
		else $error("multiply step committed outside the multiply pass");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |=> out_valid_q && state_q == S_IDLE)
		else $error("result load did not raise response valid");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DBL || state_q == S_FINISH)
		else $error("accepted request did not start work");
	a_finish_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && !out_valid_q |=> state_q == S_IDLE)
		else $error("finish stalled with an empty response register");
`endif

endmodule

// File: rtl/modular_exponentiation_core.sv
// Modular exponentiation core: power_mod = message ^ exponent mod modulus.
// Each request runs a reduction pass of the message, then one square-and-multiply step
// per exponent bit up to the highest set one; the lanes step through all W = 32 operand
// bits in each. A modulus below two skips both and gives 0. One request at a time: a new
// one is taken only once the last is finished, also while its response still waits.
// Asynchronous active-low reset sets the modulus to 2 and empties the response register.
module modular_exponentiation_core import mexp_pkg::*; (
	input logic clk,
	input logic arst_n,
	mexp_cfg_if.sink cfg,
	mexp_req_if.sink req,
	mexp_rsp_if.source rsp
);

	mexp_cmd_t cmd;
	mexp_sts_t sts;

	assign cfg.ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts (sts),
		.cmd (cmd)
	);

	mexp_datapath u_datapath (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd),
		.sts (sts),
		.cfg_we (cfg.valid),
		.cfg_data (cfg.modulus),
		.message (req.message),
		.exponent (req.exponent),
		.power_mod (rsp.power_mod)
	);

endmodule

// File: verif/tb_modular_exponentiation_core.sv
// Self-checking testbench for modular_exponentiation_core: a directed table of
// edge cases, then random requests over several moduli, checked by a predictor.
// Depends on mexp_pkg and the channel interfaces in mexp_if.sv.
module tb_modular_exponentiation_core import mexp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIR_COUNT = 24;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 41;
	localparam int PRESSURE_ITEMS = 6;
	localparam int RSP_HOLD_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_WAIT_CYCLES = 2200;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam logic FIXED_RESULT = 1'b1;
	localparam logic MODEL_RESULT = 1'b0;

	typedef struct packed {
		logic [FIELD_W-1:0] modulus;
		logic [FIELD_W-1:0] message;
		logic [FIELD_W-1:0] exponent;
		logic fixed;
		logic [FIELD_W-1:0] power_mod;
	} vector_t;

	// Rows are grouped by modulus; the first group runs on the reset value.
	vector_t dir_vectors [DIR_COUNT] = '{
		{32'h2, 32'h5, 32'h3, FIXED_RESULT, 32'h1},
		{32'h2, 32'hFFFF_FFFF, 32'h0, FIXED_RESULT, 32'h1},
		{32'h2, 32'h4, 32'h7, FIXED_RESULT, 32'h0},
		{32'hFFFF_FFFF, 32'h0, 32'h0, FIXED_RESULT, 32'h1},
		{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, FIXED_RESULT, 32'h0},
		{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, FIXED_RESULT, 32'h0},
		{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, FIXED_RESULT, 32'hFFFF_FFFE},
		{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h2, FIXED_RESULT, 32'h1},
		{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, FIXED_RESULT, 32'h1},
		{32'hFFFF_FFFF, 32'h2, 32'd31, FIXED_RESULT, 32'h8000_0000},
		{32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, MODEL_RESULT, 32'h0},
		{32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0001_0001, MODEL_RESULT, 32'h0},
		{32'h0, 32'h7, 32'h3, FIXED_RESULT, 32'h0},
		{32'h0, 32'h0, 32'h0, FIXED_RESULT, 32'h0},
		{32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FIXED_RESULT, 32'h0},
		{32'h1, 32'h5, 32'h0, FIXED_RESULT, 32'h0},
		{32'h3, 32'hFFFF_FFFF, 32'h2, FIXED_RESULT, 32'h0},
		{32'h3, 32'h2, 32'hFFFF_FFFF, FIXED_RESULT, 32'h2},
		{32'h8000_0000, 32'h3, 32'hFFFF_FFFF, MODEL_RESULT, 32'h0},
		{32'h8000_0000, 32'h8000_0000, 32'h5, FIXED_RESULT, 32'h0},
		{32'h8000_0000, 32'h7FFF_FFFF, 32'h2, FIXED_RESULT, 32'h1},
		{32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'hFFFF_FFFA, FIXED_RESULT, 32'h1},
		{32'hFFFF_FFFB, 32'hFFFF_FFFB, 32'h9, FIXED_RESULT, 32'h0},
		{32'hFFFF_FFFB, 32'hAAAA_AAAA, 32'h5555_5555, MODEL_RESULT, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mexp_cfg_if cfg_ch ();
	mexp_req_if req_ch ();
	mexp_rsp_if rsp_ch ();

	modular_exponentiation_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [FIELD_W-1:0] power_mod_expected [$];
	logic [FIELD_W-1:0] modulus_now = MODULUS_RESET;
	int error_count = 0;
	int idle_cycles = 0;
	int req_calm = 0;
	int rsp_calm = 0;
	bit rsp_hold_pending = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Right-to-left square and multiply with every product fully reduced.
	function automatic logic [FIELD_W-1:0] calc_power_mod(input logic [FIELD_W-1:0] msg,
			input logic [FIELD_W-1:0] expo, input logic [FIELD_W-1:0] mod_val);
		logic [63:0] m;
		logic [63:0] base;
		logic [63:0] acc;
		logic [OPERAND_WIDTH-1:0] e;
		m = 64'(mod_val[OPERAND_WIDTH-1:0]);
		base = 64'(msg[OPERAND_WIDTH-1:0]);
		e = expo[OPERAND_WIDTH-1:0];
		if (m < 64'd2) begin
			return '0;
		end
		base = base % m;
		acc = 64'd1;
		while (e != '0) begin
			if (e[0]) begin
				acc = (acc * base) % m;
			end
			base = (base * base) % m;
			e = e >> 1;
		end
		return acc[FIELD_W-1:0];
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch with none.
	task automatic pick_gap(inout int calm_left, output int gap);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				calm_left = $urandom_range(20, 60);
				gap = 0;
			end else if (r < 55) begin
				gap = 0;
			end else if (r < 88) begin
				gap = $urandom_range(1, 3);
			end else if (r < 97) begin
				gap = $urandom_range(4, 16);
			end else begin
				gap = $urandom_range(30, 90);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] want);
		error_count++;
		$display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
	endtask

	task automatic issue_request(input logic [FIELD_W-1:0] msg, input logic [FIELD_W-1:0] expo,
			input logic fixed, input logic [FIELD_W-1:0] fixed_value);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.message <= msg;
		req_ch.exponent <= expo;
		do @(posedge clk); while (!req_ch.ready);
		power_mod_expected.push_back(fixed ? fixed_value : calc_power_mod(msg, expo, modulus_now));
		pick_gap(req_calm, gap);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		req_ch.valid <= 1'b0;
		while (power_mod_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The modulus is only changed while the core has nothing in flight.
	task automatic load_modulus(input logic [FIELD_W-1:0] value);
		wait_results_done();
		cfg_ch.valid <= 1'b1;
		cfg_ch.modulus <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		modulus_now = value;
	endtask

	initial begin
		int i;
		int phase;
		int r;
		logic [FIELD_W-1:0] msg;
		logic [FIELD_W-1:0] expo;
		logic [FIELD_W-1:0] new_modulus;
		req_ch.valid <= 1'b0;
		req_ch.message <= '0;
		req_ch.exponent <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.modulus <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_COUNT; i++) begin
			if (dir_vectors[i].modulus != modulus_now) begin
				load_modulus(dir_vectors[i].modulus);
			end
			issue_request(dir_vectors[i].message, dir_vectors[i].exponent,
				dir_vectors[i].fixed, dir_vectors[i].power_mod);
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: new_modulus = $urandom | 32'h8000_0000;
				1: new_modulus = $urandom_range(2, 1000);
				2: new_modulus = $urandom;
				3: new_modulus = 32'hFFFF_FFFF;
				4: new_modulus = MODULUS_RESET;
				default: new_modulus = $urandom_range(3, 32'hFFFF);
			endcase
			load_modulus(new_modulus);

			// Stall the response side while short requests keep coming, so the core
			// holds a finished result, takes one more request and then backs up.
			if (phase == 2) begin
				rsp_hold_pending = 1'b1;
				for (i = 0; i < PRESSURE_ITEMS; i++) begin
					issue_request($urandom, $urandom_range(1, 15), MODEL_RESULT, '0);
				end
				wait_results_done();
			end

			for (i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 9);
				case (r)
					0: msg = '0;
					1: msg = modulus_now - 1'b1;
					2: msg = modulus_now;
					3: msg = 32'hFFFF_FFFF;
					default: msg = $urandom;
				endcase
				r = $urandom_range(0, 9);
				case (r)
					0: expo = '0;
					1: expo = 32'hFFFF_FFFF;
					2: expo = 32'h1;
					default: expo = $urandom >> $urandom_range(0, 31);
				endcase
				issue_request(msg, expo, MODEL_RESULT, '0);
			end
		end

		wait_results_done();
		repeat (END_WAIT_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("modular_exponentiation_core regression: pass");
		end else begin
			$display("modular_exponentiation_core regression: fail");
		end
		$finish;
	end

	initial begin
		int rsp_gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rsp_hold_pending) begin
				rsp_hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			pick_gap(rsp_calm, rsp_gap);
			if (rsp_gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (power_mod_expected.size() == 0) begin
				report_mismatch("response with no request pending", rsp_ch.power_mod, 'x);
			end else begin
				if (rsp_ch.power_mod !== power_mod_expected[0]) begin
					report_mismatch("power_mod", rsp_ch.power_mod, power_mod_expected[0]);
				end
				void'(power_mod_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("modular_exponentiation_core regression: fail");
			$finish;
		end
	end

endmodule

// File: modular_exponentiation_core.f
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_lane.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_core.sv
verif/tb_modular_exponentiation_core.sv
